/* hdl/ppp_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ppp_pkg
// Shared constants and types of the pinhole point projector.
// ---------------------------------------------------------------------------
package ppp_pkg;

  // configuration register indexes
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 64;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROT0    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROT1    = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROT2    = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_X = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_Y = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_Z = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTR    = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME   = 4'd7;

  localparam int ROT_BITS = 48;
  localparam logic [ROT_BITS-1:0] ROT0_RESET = 48'h0000_0000_4000;
  localparam logic [ROT_BITS-1:0] ROT1_RESET = 48'h0000_4000_0000;
  localparam logic [ROT_BITS-1:0] ROT2_RESET = 48'h4000_0000_0000;

  // projection lanes: centre column/row, top column/row
  localparam int NLANE   = 4;
  localparam int LANE_U  = 0;
  localparam int LANE_V  = 1;
  localparam int LANE_UT = 2;
  localparam int LANE_VT = 3;

  // fixed point constants, q.16 metres
  localparam int TOP_OFFSET = 19661;
  localparam int NEAR_Z     = 65536;
  localparam int FAR_Z      = 200 * 65536;
  localparam longint XY_LIMIT = 64'sd17592186044416;

  // datapath widths fixed by the field formats
  localparam int CLAMP_BITS = 46;
  localparam int PROD_BITS  = 63;
  localparam int CZ_BITS    = 40;
  localparam int MAG_BITS   = 62;
  localparam int ZIN_BITS   = 24;
  localparam int DEN_BITS   = 28;

  typedef struct packed {
    logic neg;
    logic over;
  } div_flag_t;

  typedef struct packed {
    logic [15:0] tag;
    logic        zok;
    logic        ztok;
  } div_side_t;

endpackage
`default_nettype wire

/* hdl/ppp_div.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// ---------------------------------------------------------------------------
module ppp_div
  import ppp_pkg::*;
#(
  parameter int NW  = 62,
  parameter int DW  = 28,
  parameter int QB  = 12,
  parameter int SBW = 18
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   in_mag [NLANE],
  input  wire logic            in_neg [NLANE],
  input  wire logic [DW-1:0]   in_den [NLANE],
  input  wire logic [SBW-1:0]  in_side,
  output logic                 out_valid,
  output logic [QB-1:0]        out_quo [NLANE],
  output div_flag_t            out_flag [NLANE],
  output logic [SBW-1:0]       out_side
);

  logic            vld  [QB+1];
  logic [SBW-1:0]  side [QB+1];
  logic [NW-1:0]   rem  [QB+1][NLANE];
  logic [DW-1:0]   den  [QB+1][NLANE];
  logic [QB-1:0]   quo  [QB+1][NLANE];
  div_flag_t       flag [QB+1][NLANE];

  // stage 0 flags quotients that do not fit in QB bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    side[0] <= in_side;
    for (int l = 0; l < NLANE; l++) begin
      rem[0][l]       <= in_mag[l];
      den[0][l]       <= in_den[l];
      quo[0][l]       <= '0;
      flag[0][l].neg  <= in_neg[l];
      flag[0][l].over <= in_mag[l] >= (NW'(in_den[l]) << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int B = QB - k;
    logic [NW-1:0] dsh [NLANE];

    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        dsh[l] = NW'(den[k-1][l]) << B;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      side[k] <= side[k-1];
      for (int l = 0; l < NLANE; l++) begin
        den[k][l]  <= den[k-1][l];
        flag[k][l] <= flag[k-1][l];
        if (rem[k-1][l] >= dsh[l]) begin
          rem[k][l] <= rem[k-1][l] - dsh[l];
          quo[k][l] <= quo[k-1][l] | (QB'(1) << B);
        end else begin
          rem[k][l] <= rem[k-1][l];
          quo[k][l] <= quo[k-1][l];
        end
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_side  = side[QB];
  assign out_quo   = quo[QB];
  assign out_flag  = flag[QB];

endmodule
`default_nettype wire

/* hdl/ppp_sqrt.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ppp_sqrt
// Pipelined integer square root, floor, one root bit per stage.
// ---------------------------------------------------------------------------
module ppp_sqrt
  import ppp_pkg::*;
#(
  parameter int NB  = 26,
  parameter int SBW = 40
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [NB-1:0]   in_n,
  input  wire logic [SBW-1:0]  in_side,
  output logic                 out_valid,
  output logic [NB/2-1:0]      out_root,
  output logic [SBW-1:0]       out_side
);

  localparam int RB = NB / 2;
  localparam int CB = NB + 2;

  logic            vld  [RB];
  logic [SBW-1:0]  side [RB];
  logic [NB-1:0]   rem  [RB];
  logic [RB-1:0]   root [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam int B = RB - 1 - k;
    logic            p_vld;
    logic [SBW-1:0]  p_side;
    logic [NB-1:0]   p_rem;
    logic [RB-1:0]   p_root;
    logic [CB-1:0]   cand;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_side = in_side;
      assign p_rem  = in_n;
      assign p_root = '0;
    end else begin : g_next
      assign p_vld  = vld[k-1];
      assign p_side = side[k-1];
      assign p_rem  = rem[k-1];
      assign p_root = root[k-1];
    end

    // (r + 2^B)^2 - r^2
    assign cand = (CB'(p_root) << (B + 1)) + (CB'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= p_vld;
      end
      side[k] <= p_side;
      if (CB'(p_rem) >= cand) begin
        rem[k]  <= NB'(CB'(p_rem) - cand);
        root[k] <= p_root | (RB'(1) << B);
      end else begin
        rem[k]  <= p_rem;
        root[k] <= p_root;
      end
    end
  end

  assign out_valid = vld[RB-1];
  assign out_root  = root[RB-1];
  assign out_side  = side[RB-1];

endmodule
`default_nettype wire

/* hdl/pinhole_point_projector_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pinhole_point_projector_unit
// Rotates and translates world points into the camera frame, projects them
// through a pinhole model and reports visible points with a lamp radius.
// ---------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// input    | start / busy         | point_x, point_y, point_z, signal_tag
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
// result   | result_valid strobe  | tag_out, pixel_u, pixel_v, lamp_radius
//
// one point is taken every cycle; busy stays low.
// the pipeline depth grows with PIXEL_BITS through the bit-per-stage divider and
// square root pipelines.
// reset clears the stage valid bits and loads the identity rotation.
// results are strobed for one cycle; points that are not visible give none.
// ---------------------------------------------------------------------------
module pinhole_point_projector_unit
  import ppp_pkg::*;
#(
  parameter int COORD_BITS = 40,
  parameter int PIXEL_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] point_z,
  input  wire logic [15:0]                  signal_tag,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]     cfg_data,
  output logic                              result_valid,
  output logic [15:0]                       tag_out,
  output logic [PIXEL_BITS-1:0]             pixel_u,
  output logic [PIXEL_BITS-1:0]             pixel_v,
  output logic [15:0]                       lamp_radius
);

  localparam int CW  = COORD_BITS;
  localparam int PB  = PIXEL_BITS;
  localparam int PW  = CW + 17;
  localparam int TW  = CW + 3;
  localparam int SW  = CW + 6;
  localparam int LW  = (SW > CLAMP_BITS) ? SW : CLAMP_BITS;
  localparam int FW  = 2 * PB + 1;
  localparam int SQ  = 2 * PB + 1;
  localparam int NB  = 2 * PB + 2;
  localparam int RB  = PB + 1;
  localparam int SSB = 16 + 2 * PB;

  // configuration registers
  logic [ROT_BITS-1:0]  rot [3];
  logic signed [CW-1:0] shift [3];
  logic [63:0]          intr;
  logic [FW-1:0]        frame;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]   <= ROT0_RESET;
      rot[1]   <= ROT1_RESET;
      rot[2]   <= ROT2_RESET;
      shift[0] <= '0;
      shift[1] <= '0;
      shift[2] <= '0;
      intr     <= '0;
      frame    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT0:    rot[0]   <= cfg_data[ROT_BITS-1:0];
        REG_ROT1:    rot[1]   <= cfg_data[ROT_BITS-1:0];
        REG_ROT2:    rot[2]   <= cfg_data[ROT_BITS-1:0];
        REG_SHIFT_X: shift[0] <= cfg_data[CW-1:0];
        REG_SHIFT_Y: shift[1] <= cfg_data[CW-1:0];
        REG_SHIFT_Z: shift[2] <= cfg_data[CW-1:0];
        REG_INTR:    intr     <= cfg_data;
        REG_FRAME:   frame    <= cfg_data[FW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] rmat [3][3];
  logic [15:0]        fx, fy, cx, cy;
  logic [PB-1:0]      img_w, img_h;
  logic               img_flip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rmat[i][j] = rot[i][16*j +: 16];
      end
    end
  end

  assign fx       = intr[15:0];
  assign fy       = intr[31:16];
  assign cx       = intr[47:32];
  assign cy       = intr[63:48];
  assign img_w    = frame[PB-1:0];
  assign img_h    = frame[2*PB-1:PB];
  assign img_flip = frame[2*PB];

  function automatic logic signed [CLAMP_BITS-1:0] clamp_xy(input logic signed [SW-1:0] v);
    logic signed [LW-1:0] e;
    e = LW'(v);
    if (e > LW'(XY_LIMIT)) begin
      return CLAMP_BITS'(XY_LIMIT);
    end else if (e < LW'(-XY_LIMIT)) begin
      return CLAMP_BITS'(-XY_LIMIT);
    end
    return CLAMP_BITS'(e);
  endfunction

  // stage 1: input register, top point z
  logic               s1_valid;
  logic [15:0]        s1_tag;
  logic signed [CW:0] s1_pt [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_tag   <= signal_tag;
    s1_pt[0] <= (CW+1)'(point_x);
    s1_pt[1] <= (CW+1)'(point_y);
    s1_pt[2] <= (CW+1)'(point_z);
    s1_pt[3] <= (CW+1)'(point_z) + (CW+1)'(TOP_OFFSET);
  end

  // stage 2: rotation products, column 3 is the top point z term
  logic signed [PW-1:0] prod [3][4];
  logic                 s2_valid;
  logic [15:0]          s2_tag;
  logic signed [TW-1:0] s2_t [3][4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod[i][j] = PW'(rmat[i][(j == 3) ? 2 : j]) * PW'(s1_pt[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_tag <= s1_tag;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        s2_t[i][j] <= TW'(prod[i][j] >>> 14);
      end
    end
  end

  // stage 3: camera coordinates, 0..2 centre, 3..5 top point
  logic                 s3_valid;
  logic [15:0]          s3_tag;
  logic signed [SW-1:0] s3_c [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_tag <= s2_tag;
    for (int i = 0; i < 3; i++) begin
      s3_c[i]   <= SW'(s2_t[i][0]) + SW'(s2_t[i][1]) + SW'(s2_t[i][2]) + SW'(shift[i]);
      s3_c[3+i] <= SW'(s2_t[i][0]) + SW'(s2_t[i][1]) + SW'(s2_t[i][3]) + SW'(shift[i]);
    end
  end

  // stage 4: clamp, depth check, focal and centre products
  logic                        s4_valid;
  logic [15:0]                 s4_tag;
  logic                        s4_zok [2];
  logic [DEN_BITS-1:0]         s4_den [2];
  logic signed [PROD_BITS-1:0] s4_pf [NLANE];
  logic [CZ_BITS-1:0]          s4_cz [NLANE];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_tag <= s3_tag;
    for (int k = 0; k < 2; k++) begin
      s4_zok[k] <= s3_c[3*k+2] >= SW'(NEAR_Z) && s3_c[3*k+2] <= SW'(FAR_Z);
      s4_den[k] <= {s3_c[3*k+2][ZIN_BITS-1:0], 4'b0000};
      s4_pf[2*k]   <= PROD_BITS'(clamp_xy(s3_c[3*k])) * PROD_BITS'($signed({1'b0, fx}));
      s4_pf[2*k+1] <= PROD_BITS'(clamp_xy(s3_c[3*k+1])) * PROD_BITS'($signed({1'b0, fy}));
      s4_cz[2*k]   <= CZ_BITS'(cx) * CZ_BITS'(s3_c[3*k+2][ZIN_BITS-1:0]);
      s4_cz[2*k+1] <= CZ_BITS'(cy) * CZ_BITS'(s3_c[3*k+2][ZIN_BITS-1:0]);
    end
  end

  // stage 5: numerators, split into sign and magnitude
  logic signed [PROD_BITS-1:0] num [NLANE];
  logic                        s5_valid;
  div_side_t                   s5_side;
  logic [MAG_BITS-1:0]         s5_mag [NLANE];
  logic                        s5_neg [NLANE];
  logic [DEN_BITS-1:0]         s5_den [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      num[l] = s4_pf[l] + PROD_BITS'($signed({1'b0, s4_cz[l]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_side.tag  <= s4_tag;
    s5_side.zok  <= s4_zok[0];
    s5_side.ztok <= s4_zok[1];
    for (int l = 0; l < NLANE; l++) begin
      s5_neg[l] <= num[l][PROD_BITS-1];
      s5_mag[l] <= MAG_BITS'(num[l][PROD_BITS-1] ? -num[l] : num[l]);
      s5_den[l] <= s4_den[l / 2];
    end
  end

  logic          dv_valid;
  logic [PB-1:0] dq [NLANE];
  div_flag_t     dflag [NLANE];
  div_side_t     dside;

  ppp_div #(
    .NW  (MAG_BITS),
    .DW  (DEN_BITS),
    .QB  (PB),
    .SBW ($bits(div_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .in_mag    (s5_mag),
    .in_neg    (s5_neg),
    .in_den    (s5_den),
    .in_side   (s5_side),
    .out_valid (dv_valid),
    .out_quo   (dq),
    .out_flag  (dflag),
    .out_side  (dside)
  );

  // stage 6: visibility and flip
  logic                lane_vis [NLANE];
  logic                top_vis;
  logic                s6_valid;
  logic [15:0]         s6_tag;
  logic [PB-1:0]       s6_u, s6_v;
  logic signed [PB:0]  s6_ut, s6_vt;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      // a small negative value truncates to zero and still counts
      lane_vis[l] = !dflag[l].over && (dflag[l].neg ? (dq[l] == '0) :
                    (dq[l] <= ((l == LANE_U || l == LANE_UT) ? img_w : img_h)));
    end
  end

  assign top_vis = dside.ztok && lane_vis[LANE_UT] && lane_vis[LANE_VT];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= dv_valid && dside.zok && lane_vis[LANE_U] && lane_vis[LANE_V];
    end
    s6_tag <= dside.tag;
    s6_u   <= dq[LANE_U];
    s6_v   <= img_flip ? img_h - dq[LANE_V] : dq[LANE_V];
    s6_ut  <= top_vis ? $signed({1'b0, dq[LANE_UT]}) : '1;
    s6_vt  <= top_vis ? $signed({1'b0, img_flip ? img_h - dq[LANE_VT] : dq[LANE_VT]}) : '1;
  end

  // stage 7: offsets to the top point, squared
  logic signed [PB:0]     du, dv;
  logic signed [2*PB+1:0] du_sq, dv_sq;
  logic                   s7_valid;
  logic [15:0]            s7_tag;
  logic [PB-1:0]          s7_u, s7_v;
  logic [SQ-1:0]          s7_sqa, s7_sqb;

  assign du    = s6_ut - $signed({1'b0, s6_u});
  assign dv    = s6_vt - $signed({1'b0, s6_v});
  assign du_sq = (2*PB+2)'(du) * (2*PB+2)'(du);
  assign dv_sq = (2*PB+2)'(dv) * (2*PB+2)'(dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    s7_tag <= s6_tag;
    s7_u   <= s6_u;
    s7_v   <= s6_v;
    s7_sqa <= du_sq[SQ-1:0];
    s7_sqb <= dv_sq[SQ-1:0];
  end

  // stage 8: squared distance
  logic           s8_valid;
  logic [SSB-1:0] s8_side;
  logic [NB-1:0]  s8_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= s7_valid;
    end
    s8_side <= {s7_tag, s7_u, s7_v};
    s8_n    <= NB'(s7_sqa) + NB'(s7_sqb);
  end

  logic           sq_valid;
  logic [RB-1:0]  sq_root;
  logic [SSB-1:0] sq_side;

  ppp_sqrt #(
    .NB  (NB),
    .SBW (SSB)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s8_valid),
    .in_n      (s8_n),
    .in_side   (s8_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // result register, radius saturates at 16 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= sq_valid;
    end
    tag_out     <= sq_side[SSB-1 -: 16];
    pixel_u     <= sq_side[2*PB-1:PB];
    pixel_v     <= sq_side[PB-1:0];
    lamp_radius <= ((sq_root >> 16) != '0) ? 16'hFFFF : 16'(sq_root);
  end

endmodule
`default_nettype wire

/* bench/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the pinhole point projector. A directed table runs
// at reset settings and on a plain camera. Random phases then follow, each
// with its own rotation, shift, intrinsics and image frame. Points past the
// reset table go through a local projection model. Visible points queue an
// expected beat, and each result beat is checked against the oldest one.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ppp_pkg::*;

  localparam int     COORD   = 40;
  localparam int     PIX     = 12;
  localparam int     LATENCY = 2 * PIX + 11;
  localparam longint LIMIT   = 200000;
  localparam longint ONE_M   = 65536;
  localparam logic signed [COORD-1:0] PMAX = {1'b0, {(COORD-1){1'b1}}};
  localparam logic signed [COORD-1:0] PMIN = {1'b1, {(COORD-1){1'b0}}};

  typedef struct packed {
    logic [15:0]    tag;
    logic [PIX-1:0] u;
    logic [PIX-1:0] v;
    logic [15:0]    radius;
  } lamp_t;

  typedef struct packed {
    logic signed [COORD-1:0] x;
    logic signed [COORD-1:0] y;
    logic signed [COORD-1:0] z;
    logic [15:0]             tag;
    bit                      typed;
    bit                      shows;
    lamp_t                   lamp;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [COORD-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic [15:0]             signal_tag = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_ROT0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                    result_valid;
  logic [15:0]             tag_out;
  logic [PIX-1:0]          pixel_u, pixel_v;
  logic [15:0]             lamp_radius;

  // camera settings as the block should hold them
  logic [47:0] rot_q [3];
  longint      shift_q [3];
  logic [63:0] intr_q;
  logic [24:0] frame_q;

  lamp_t  lamp_q [$];
  int     fails = 0;
  longint cycles = 0;
  bit     use_typed = 0;
  stim_row_t typed_row;

  pinhole_point_projector_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .signal_tag(signal_tag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid), .tag_out(tag_out), .pixel_u(pixel_u),
    .pixel_v(pixel_v), .lamp_radius(lamp_radius)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    fails++;
  endtask

  function automatic longint isqrt(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // camera transform and pinhole projection; returns visibility
  function automatic bit project(input longint px, py, pz, output longint u, v);
    longint p [3];
    longint cam [3];
    longint fx, fy, cx, cy, w, h, uu, vv, lim;
    p[0] = px; p[1] = py; p[2] = pz;
    lim = XY_LIMIT;
    for (int i = 0; i < 3; i++) begin
      cam[i] = shift_q[i];
      for (int j = 0; j < 3; j++)
        cam[i] += (longint'($signed(rot_q[i][16*j +: 16])) * p[j]) >>> 14;
    end
    for (int i = 0; i < 2; i++) begin
      if (cam[i] > lim) cam[i] = lim;
      if (cam[i] < -lim) cam[i] = -lim;
    end
    fx = intr_q[15:0];
    fy = intr_q[31:16];
    cx = intr_q[47:32];
    cy = intr_q[63:48];
    w = frame_q[PIX-1:0];
    h = frame_q[2*PIX-1:PIX];
    u = -1;
    v = -1;
    if (cam[2] < NEAR_Z || cam[2] > FAR_Z) return 0;
    uu = (cam[0] * fx + cx * cam[2]) / (16 * cam[2]);
    vv = (cam[1] * fy + cy * cam[2]) / (16 * cam[2]);
    if (uu < 0 || uu > w || vv < 0 || vv > h) return 0;
    if (frame_q[2*PIX]) vv = h - vv;
    u = uu;
    v = vv;
    return 1;
  endfunction

  function automatic bit predict_lamp(input longint px, py, pz, input logic [15:0] tag,
                                      output lamp_t lamp);
    longint u, v, ut, vt, r;
    bit seen;
    lamp = '0;
    if (!project(px, py, pz, u, v)) return 0;
    seen = project(px, py, pz + TOP_OFFSET, ut, vt);
    r = isqrt(longint'(unsigned'((ut - u) * (ut - u) + (vt - v) * (vt - v))));
    if (r > 65535) r = 65535;
    lamp.tag = tag;
    lamp.u = u[PIX-1:0];
    lamp.v = v[PIX-1:0];
    lamp.radius = r[15:0];
    return 1;
  endfunction

  // follow config writes and accepted points, check result beats
  always @(posedge clk) begin
    lamp_t got, want;
    if (rst) begin
      rot_q[0] = ROT0_RESET; rot_q[1] = ROT1_RESET; rot_q[2] = ROT2_RESET;
      shift_q[0] = 0; shift_q[1] = 0; shift_q[2] = 0;
      intr_q = '0;
      frame_q = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROT0:    rot_q[0] = cfg_data[47:0];
          REG_ROT1:    rot_q[1] = cfg_data[47:0];
          REG_ROT2:    rot_q[2] = cfg_data[47:0];
          REG_SHIFT_X: shift_q[0] = longint'($signed(cfg_data[COORD-1:0]));
          REG_SHIFT_Y: shift_q[1] = longint'($signed(cfg_data[COORD-1:0]));
          REG_SHIFT_Z: shift_q[2] = longint'($signed(cfg_data[COORD-1:0]));
          REG_INTR:    intr_q = cfg_data;
          REG_FRAME:   frame_q = cfg_data[24:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (use_typed) begin
          if (typed_row.shows) lamp_q = {lamp_q, typed_row.lamp};
        end else if (predict_lamp(point_x, point_y, point_z, signal_tag, want)) begin
          lamp_q = {lamp_q, want};
        end
      end
      if (result_valid) begin
        got = '{tag_out, pixel_u, pixel_v, lamp_radius};
        if (lamp_q.size() == 0) begin
          report($sformatf("unexpected beat tag %h", tag_out));
        end else begin
          want = lamp_q.pop_front();
          if (got.tag != want.tag)
            report($sformatf("tag %h, want %h", got.tag, want.tag));
          if (got.u != want.u)
            report($sformatf("tag %h pixel_u %0d, want %0d", want.tag, got.u, want.u));
          if (got.v != want.v)
            report($sformatf("tag %h pixel_v %0d, want %0d", want.tag, got.v, want.v));
          if (got.radius != want.radius)
            report($sformatf("tag %h radius %0d, want %0d", want.tag, got.radius,
                             want.radius));
        end
      end
    end
  end

  task automatic send_point(input logic signed [COORD-1:0] x, y, z, input logic [15:0] tag);
    @(negedge clk);
    start <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    signal_tag <= tag;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    pause(1);
    while (lamp_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] rot_entry(input int mode, input bit diag);
    int pick;
    if (mode == 0) return diag ? 16'h4000 : 16'h0000;
    if (mode == 2) return 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 3);
    return pick == 0 ? 16'h4000 : pick == 1 ? 16'hC000 : 16'h0000;
  endfunction

  function automatic logic signed [COORD-1:0] near_shift();
    return $signed(COORD'($urandom_range(0, 20 * ONE_M))) - COORD'(10 * ONE_M);
  endfunction

  stim_row_t reset_rows [8] = '{
    '{0, 0, ONE_M, 16'h0000, 1, 1, '{16'h0000, 0, 0, 0}},
    '{0, 0, 200 * ONE_M, 16'hFFFF, 1, 1, '{16'hFFFF, 0, 0, 1}},
    '{0, 0, 200 * ONE_M + 1, 16'h0001, 1, 0, '0},
    '{0, 0, ONE_M - 1, 16'h0002, 1, 0, '0},
    '{PMAX, PMIN, ONE_M, 16'h0003, 1, 1, '{16'h0003, 0, 0, 0}},
    '{PMIN, PMAX, 200 * ONE_M, 16'h0004, 1, 1, '{16'h0004, 0, 0, 1}},
    '{0, 0, PMIN, 16'h0005, 1, 0, '0},
    '{0, 0, PMAX, 16'h0006, 1, 0, '0}
  };

  // 1280x720 camera, focal 1000 px, centered principal point
  stim_row_t camera_rows [10] = '{
    '{0, 0, ONE_M, 16'h1000, 0, 0, '0},
    '{0, 0, 10 * ONE_M, 16'h1001, 0, 0, '0},
    '{-419430, 0, 10 * ONE_M, 16'h1002, 0, 0, '0},
    '{419430, 0, 10 * ONE_M, 16'h1003, 0, 0, '0},
    '{0, -235930, 10 * ONE_M, 16'h1004, 0, 0, '0},
    '{0, 235930, 10 * ONE_M, 16'h1005, 0, 0, '0},
    '{500000, 0, 10 * ONE_M, 16'h1006, 0, 0, '0},
    '{ONE_M, ONE_M, 200 * ONE_M, 16'h1007, 0, 0, '0},
    '{0, 0, ONE_M - 19661, 16'h1008, 0, 0, '0},
    '{-ONE_M, -ONE_M, 2 * ONE_M, 16'h1009, 0, 0, '0}
  };

  initial begin
    int mode, w, h;
    logic signed [COORD-1:0] x, y, z;
    logic [63:0] fxy;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    use_typed = 1;
    foreach (reset_rows[i]) begin
      // takes effect after the checker has seen the previous beat
      typed_row <= reset_rows[i];
      send_point(reset_rows[i].x, reset_rows[i].y, reset_rows[i].z, reset_rows[i].tag);
    end
    pause(1);
    use_typed = 0;
    drain();

    write_reg(REG_INTR, {16'd5760, 16'd10240, 16'd16000, 16'd16000});
    write_reg(REG_FRAME, 64'(1 << 2*PIX) | 64'(720 << PIX) | 64'd1280);
    foreach (camera_rows[i])
      send_point(camera_rows[i].x, camera_rows[i].y, camera_rows[i].z, camera_rows[i].tag);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      mode = phase < 3 ? phase : $urandom_range(0, 2);
      for (int r = 0; r < 3; r++)
        write_reg(CFG_IDX_BITS'(r), {16'($urandom()), rot_entry(mode, r == 2),
                                     rot_entry(mode, r == 1), rot_entry(mode, r == 0)});
      for (int s = 0; s < 3; s++) begin
        if (phase == 4) z = s[0] ? PMIN : PMAX;
        else z = near_shift();
        write_reg(CFG_IDX_BITS'(REG_SHIFT_X + s), {{24{z[COORD-1]}}, z});
      end
      w = $urandom_range(64, 4095);
      h = $urandom_range(64, 4095);
      fxy = {16'(h * 8), 16'(w * 8), 16'($urandom_range(2000, 65535)),
             16'($urandom_range(2000, 65535))};
      if (phase == 5) fxy = '1;
      if (phase == 6) fxy = '0;
      write_reg(REG_INTR, fxy);
      write_reg(REG_FRAME, phase == 5 ? 64'h1FF_FFFF | (rand64() << 25)
                           : {39'(rand64()), 1'($urandom()), 12'(h), 12'(w)});
      write_reg(CFG_IDX_BITS'($urandom_range(8, 15)), rand64());

      for (int n = 0; n < 65; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          x = {$urandom(), 8'($urandom())};
          y = {$urandom(), 8'($urandom())};
          z = {$urandom(), 8'($urandom())};
        end else begin
          z = COORD'($urandom_range(ONE_M / 2, 210 * ONE_M));
          x = $signed(COORD'($urandom_range(0, 32'(2 * z)))) - z;
          y = $signed(COORD'($urandom_range(0, 32'(2 * z)))) - z;
        end
        send_point(x, y, z, 16'($urandom()));
        if (phase < 8 && $urandom_range(0, 7) == 0) pause($urandom_range(1, 12));
        // let everything in flight come out once mid-phase
        if (phase == 3 && n == 30) begin
          pause(1);
          while (lamp_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
